@@ hw/rtl/t2c_pkg.sv @@
`timescale 1ns / 1ps

package t2c_pkg;

	// one decoded step: up to three output bytes, oldest in slot 0
	typedef struct packed {
		logic [1:0]      cnt;
		logic            last;
		logic [2:0][7:0] bytes;
	} t2c_job_t;

	// a pair match result
	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} t2c_hit_t;

	localparam logic [7:0] CYR_SCH_UP = 8'hD9;
	localparam logic [7:0] CYR_SCH_LO = 8'hF9;

	// single letter to cp1251, anything else passes through
	function automatic logic [7:0] t2c_single(input logic [7:0] x);
		logic [7:0] r;
		case (x)
			"A": r = 8'hC0;
			"B": r = 8'hC1;
			"V": r = 8'hC2;
			"G": r = 8'hC3;
			"D": r = 8'hC4;
			"E": r = 8'hC5;
			"Z": r = 8'hC7;
			"I": r = 8'hC8;
			"J": r = 8'hC9;
			"K": r = 8'hCA;
			"L": r = 8'hCB;
			"M": r = 8'hCC;
			"N": r = 8'hCD;
			"O": r = 8'hCE;
			"P": r = 8'hCF;
			"R": r = 8'hD0;
			"S": r = 8'hD1;
			"T": r = 8'hD2;
			"U": r = 8'hD3;
			"F": r = 8'hD4;
			"Y": r = 8'hDB;
			"a": r = 8'hE0;
			"b": r = 8'hE1;
			"v": r = 8'hE2;
			"g": r = 8'hE3;
			"d": r = 8'hE4;
			"e": r = 8'hE5;
			"z": r = 8'hE7;
			"i": r = 8'hE8;
			"j": r = 8'hE9;
			"k": r = 8'hEA;
			"l": r = 8'hEB;
			"m": r = 8'hEC;
			"n": r = 8'hED;
			"o": r = 8'hEE;
			"p": r = 8'hEF;
			"r": r = 8'hF0;
			"s": r = 8'hF1;
			"t": r = 8'hF2;
			"u": r = 8'hF3;
			"f": r = 8'hF4;
			"y": r = 8'hFB;
			default: r = x;
		endcase
		return r;
	endfunction

	// byte that opens some two or three letter entry
	function automatic logic t2c_starter(input logic [7:0] x);
		logic r;
		case (x)
			"S", "s", "Y", "y", "Z", "z", "K", "k", "T", "t", "C", "c": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// two bytes that open a three letter entry
	function automatic logic t2c_sch_pref(input logic [7:0] x, input logic [7:0] y);
		logic r;
		case ({x, y})
			"Sc", "SC", "sc": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// two letter entries
	function automatic t2c_hit_t t2c_pair(input logic [7:0] x, input logic [7:0] y);
		t2c_hit_t r;
		r.hit = 1'b1;
		case ({x, y})
			"Yo", "YO": r.code = 8'hA8;
			"yo": r.code = 8'hB8;
			"Zh", "ZH": r.code = 8'hC6;
			"zh": r.code = 8'hE6;
			"Kh", "KH": r.code = 8'hD5;
			"kh": r.code = 8'hF5;
			"Ts", "TS": r.code = 8'hD6;
			"ts": r.code = 8'hF6;
			"Ch", "CH": r.code = 8'hD7;
			"ch": r.code = 8'hF7;
			"Sh", "SH": r.code = 8'hD8;
			"sh": r.code = 8'hF8;
			"Yu", "YU": r.code = 8'hDE;
			"yu": r.code = 8'hFE;
			"Ya", "YA": r.code = 8'hDF;
			"ya": r.code = 8'hFF;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

	// three letter entries
	function automatic t2c_hit_t t2c_tri(input logic [7:0] x, input logic [7:0] y,
		input logic [7:0] z);
		t2c_hit_t r;
		r.hit = 1'b1;
		case ({x, y, z})
			"Sch", "SCH": r.code = CYR_SCH_UP;
			"sch": r.code = CYR_SCH_LO;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/t2c_front.sv @@
`timescale 1ns / 1ps

module t2c_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               word_end,
	input  logic               q_full,
	output logic               push,
	output t2c_pkg::t2c_job_t  job
);
	import t2c_pkg::*;

	logic [1:0]      pend_cnt_q;
	logic [7:0]      pend_q [2];
	logic [7:0]      wx;
	logic            grow2;
	t2c_hit_t        pr;
	t2c_hit_t        tr;
	logic [1:0]      w2_n;
	logic [7:0]      w2_b0;
	logic [7:0]      w2_b1;
	logic [1:0]      w2_hold;
	logic [7:0]      w2_h0;
	logic [7:0]      w2_h1;
	logic [1:0]      nxt_n;
	logic [2:0][7:0] nxt_b;
	logic [1:0]      nxt_hold;
	logic [7:0]      nxt_h0;
	logic [7:0]      nxt_h1;
	logic            accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// two byte window: the last held byte and the incoming one
	assign wx    = (pend_cnt_q == 2'd2) ? pend_q[1] : pend_q[0];
	assign grow2 = !word_end && t2c_sch_pref(wx, in_byte);
	assign pr    = t2c_pair(wx, in_byte);
	assign tr    = t2c_tri(pend_q[0], pend_q[1], in_byte);

	always_comb begin
		w2_n    = 2'd0;
		w2_b0   = t2c_single(wx);
		w2_b1   = t2c_single(in_byte);
		w2_hold = 2'd0;
		w2_h0   = wx;
		w2_h1   = in_byte;
		if (grow2) begin
			w2_hold = 2'd2;
		end else if (pr.hit) begin
			w2_n  = 2'd1;
			w2_b0 = pr.code;
		end else if (!word_end && t2c_starter(in_byte)) begin
			w2_n    = 2'd1;
			w2_hold = 2'd1;
			w2_h0   = in_byte;
		end else begin
			w2_n = 2'd2;
		end
	end

	// resolve held bytes plus the new byte
	always_comb begin
		nxt_n    = 2'd0;
		nxt_b    = '0;
		nxt_hold = 2'd0;
		nxt_h0   = in_byte;
		nxt_h1   = in_byte;
		case (pend_cnt_q)
			2'd1: begin
				nxt_n    = w2_n;
				nxt_b[0] = w2_b0;
				nxt_b[1] = w2_b1;
				nxt_hold = w2_hold;
				nxt_h0   = w2_h0;
				nxt_h1   = w2_h1;
			end
			2'd2: begin
				if (tr.hit) begin
					nxt_n    = 2'd1;
					nxt_b[0] = tr.code;
				end else begin
					nxt_n    = w2_n + 2'd1;
					nxt_b[0] = t2c_single(pend_q[0]);
					nxt_b[1] = w2_b0;
					nxt_b[2] = w2_b1;
					nxt_hold = w2_hold;
					nxt_h0   = w2_h0;
					nxt_h1   = w2_h1;
				end
			end
			default: begin
				if (!word_end && t2c_starter(in_byte)) begin
					nxt_hold = 2'd1;
				end else begin
					nxt_n    = 2'd1;
					nxt_b[0] = t2c_single(in_byte);
				end
			end
		endcase
	end

	assign push      = accept && (nxt_n != 2'd0);
	assign job.cnt   = nxt_n;
	assign job.last  = word_end;
	assign job.bytes = nxt_b;

	// held prefix count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
		end else if (accept) begin
			pend_cnt_q <= nxt_hold;
		end
	end

	// held prefix bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q[0] <= nxt_h0;
			pend_q[1] <= nxt_h1;
		end
	end

endmodule

@@ hw/rtl/t2c_queue.sv @@
`timescale 1ns / 1ps

module t2c_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  t2c_pkg::t2c_job_t  wr_job,
	input  logic               pop,
	output t2c_pkg::t2c_job_t  rd_job,
	output logic               full,
	output logic               empty
);
	import t2c_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	t2c_job_t        mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full   = (cnt_q == CntW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

@@ hw/rtl/t2c_back.sv @@
`timescale 1ns / 1ps

module t2c_back (
	input  logic               clk,
	input  logic               arst_n,
	input  t2c_pkg::t2c_job_t  job,
	input  logic               q_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               out_last
);
	import t2c_pkg::*;

	logic [1:0] sel_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       can_load;
	logic       load;
	logic       job_done;

	assign can_load = !out_valid_q || !out_stall;
	assign load     = can_load && !q_empty;
	assign job_done = (sel_q == job.cnt - 2'd1);
	assign pop      = load && job_done;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// output register and byte select within the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 2'd0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			sel_q       <= job_done ? 2'd0 : sel_q + 2'd1;
		end else if (can_load) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= job.bytes[sel_q];
			out_last_q <= job.last && job_done;
		end
	end

endmodule

@@ hw/rtl/translit_to_cp1251_decoder.sv @@
`timescale 1ns / 1ps

// channel  | signals                          | direction
// ---------+----------------------------------+----------
// input    | in_valid in_stall in_byte word_end | into block
// output   | out_valid out_stall out_byte out_last | out of block
//
// one input byte per cycle; each decode step is resolved in the cycle it is taken
// a step of n bytes (up to three) stays at the queue head until all n are sent
// the input stalls only while the step queue between front and back is full
// a step's bytes pass through the queue storage and then the output register
// reset clears the held prefix count, queue pointers and level, and output valid

module translit_to_cp1251_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       word_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import t2c_pkg::*;

	t2c_job_t wr_job;
	t2c_job_t rd_job;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;

	// classify and resolve prefixes
	t2c_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.word_end (word_end),
		.q_full   (q_full),
		.push     (push),
		.job      (wr_job)
	);

	// step queue
	t2c_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// serialize steps to output bytes
	t2c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	// a word end transaction always produces at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && word_end) |-> push)
		else $error("word end without output step");

	// queue never written while full
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue overflow");

	// queue never read while empty
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue underflow");

	// every queued step carries at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wr_job.cnt != 2'd0))
		else $error("empty step queued");

endmodule
